[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/dgts_pkg.sv]
// Package with sizes and types for the graph analysis block.
package dgts_pkg;
    localparam int MaxVertices = 32;
    localparam int MaxDegree   = 32;
    localparam int VW = $clog2(MaxVertices);
    localparam int DW = $clog2(MaxDegree);
    localparam int AW = VW + DW;
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [5:0] from_vertex;
        logic [5:0] to_vertex;
    } t_in_item;

    typedef struct packed {
        logic       acyclic;
        logic [4:0] component;
        logic [5:0] vertex;
        logic       last;
    } t_out_item;

    // Adjacency store request from the sequencer.
    typedef struct packed {
        logic          wr_succ;
        logic          wr_pred;
        logic [AW-1:0] succ_waddr;
        logic [AW-1:0] pred_waddr;
        logic [VW-1:0] succ_wdata;
        logic [VW-1:0] pred_wdata;
        logic          rd_pred;
        logic [AW-1:0] raddr;
    } t_adj_req;
endpackage

[rtl/core/dgts_if.sv]
// Valid/ready channel interfaces for input and result items.
interface dgts_in_if;
    logic              valid;
    logic              ready;
    dgts_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dgts_out_if;
    logic               valid;
    logic               ready;
    dgts_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/digraph_topo_sort_and_scc.sv]
// Top level: edge loading, depth-first sequencer, and result output.
// An edge with an endpoint out of range is dropped without a scan. Otherwise a
// serial duplicate scan reads each stored successor of the tail over the successor
// memory read port and compares it, stopping early when a duplicate is found.
// A run does a forward depth-first pass: a scan for unvisited vertices, walks
// with a start and a final check, a read per edge visit and a step per finished
// vertex. When a cycle exists a reversed pass over predecessor lists follows,
// with a scan per component search for the latest finish. Results of a walk
// are issued one per cycle while the receiver is ready, and a final clear
// state resets degrees and marks.
// The block is not ready while an item is in work or a result is pending.
`include "assert_macros.svh"
module digraph_topo_sort_and_scc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    dgts_in_if.sink     i_in,
    dgts_out_if.source  o_out
);
    localparam int VW = dgts_pkg::VW;
    localparam int DW = dgts_pkg::DW;
    localparam int NV = dgts_pkg::MaxVertices;
    localparam int ND = dgts_pkg::MaxDegree;
    localparam int CW = VW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DUP_REQ, S_DUP_CHK, S_DFS_START, S_DFS_TOP, S_DFS_WAIT,
        S_DFS_EDGE, S_SCAN, S_EMIT, S_CLEAR
    } t_state;

    t_state             r_state;
    logic [5:0]         r_vcount;
    logic [CW-1:0]      r_n;
    logic [DW:0]        r_outdeg [NV];
    logic [DW:0]        r_indeg  [NV];
    logic [NV-1:0]      r_visited;
    logic [NV-1:0]      r_onpath;
    logic [CW-1:0]      r_finish [NV];
    logic [VW-1:0]      r_wv [NV];
    logic [DW:0]        r_we [NV];
    logic [CW-1:0]      r_depth;
    logic [VW-1:0]      r_ord [NV];
    logic [CW-1:0]      r_ocnt;
    logic               r_cycle;
    logic               r_rev;
    logic [CW-1:0]      r_fcnt;
    logic [CW-1:0]      r_scan;
    logic [VW-1:0]      r_best;
    logic [CW-1:0]      r_bestf;
    logic               r_bestok;
    logic [4:0]         r_comp;
    logic [VW-1:0]      r_a;
    logic [VW-1:0]      r_b;
    logic [DW:0]        r_k;
    logic               r_ovalid;
    dgts_pkg::t_out_item r_odata;
    dgts_pkg::t_adj_req w_req;
    logic [VW-1:0]      w_rdata;

    dgts_adj_mem u_mem (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    logic [CW-1:0] w_top;
    logic [VW-1:0] w_v;
    logic [DW:0]   w_deg;
    logic [6:0]    w_from, w_to;
    logic [CW-1:0] w_n;
    logic          w_final;
    assign w_top  = r_depth - CW'(1);
    assign w_v    = r_wv[w_top[VW-1:0]];
    assign w_deg  = r_rev ? r_indeg[w_v] : r_outdeg[w_v];
    assign w_from = {1'b0, i_in.data.from_vertex};
    assign w_to   = {1'b0, i_in.data.to_vertex};
    // Vertex count in use, limited to the store size.
    assign w_n    = (r_vcount > 6'(NV)) ? CW'(NV) : CW'(r_vcount);
    // The next emission is the final one of the run when no more vertices follow.
    assign w_final = (r_ocnt == CW'(1)) &&
                     (!r_cycle || (r_visited | ~((NV'(1) << r_n) - NV'(1))) == '1);

    // Memory request: writes on edge insert, reads for scans and walks.
    always_comb begin
        w_req = '0;
        w_req.succ_waddr = {r_a, r_outdeg[r_a][DW-1:0]};
        w_req.pred_waddr = {r_b, r_indeg[r_b][DW-1:0]};
        w_req.succ_wdata = r_b;
        w_req.pred_wdata = r_a;
        if (r_state == S_DUP_REQ) begin
            w_req.raddr = {r_a, r_k[DW-1:0]};
        end else begin
            w_req.raddr  = {w_v, r_we[w_top[VW-1:0]][DW-1:0]};
            w_req.rd_pred = r_rev;
        end
        if (r_state == S_DUP_REQ && r_k >= r_outdeg[r_a]) begin
            w_req.wr_succ = (r_outdeg[r_a] < (DW+1)'(ND)) && (r_indeg[r_b] < (DW+1)'(ND));
            w_req.wr_pred = w_req.wr_succ;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // Sequencer with all state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= 6'd32;
            r_ovalid <= 1'b0;
            r_depth  <= '0;
            r_ocnt   <= '0;
            r_cycle  <= 1'b0;
            r_visited <= '0;
            r_onpath <= '0;
            for (int i = 0; i < NV; i++) begin
                r_outdeg[i] <= '0;
                r_indeg[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_n <= w_n;
                    if (i_in.valid && i_in.ready) begin
                        if (i_in.data.kind == dgts_pkg::KIND_RUN) begin
                            r_visited <= '0;
                            r_onpath  <= '0;
                            r_ocnt    <= '0;
                            r_fcnt    <= '0;
                            r_cycle   <= 1'b0;
                            r_rev     <= 1'b0;
                            r_scan    <= '0;
                            r_comp    <= '0;
                            r_state   <= S_SCAN;
                        end else if (w_from >= 7'd1 && w_to >= 7'd1 &&
                                     w_from <= 7'(w_n) && w_to <= 7'(w_n)) begin
                            r_a <= VW'(w_from - 7'd1);
                            r_b <= VW'(w_to - 7'd1);
                            r_k <= '0;
                            r_state <= S_DUP_REQ;
                        end
                    end
                end
                S_DUP_REQ: begin
                    if (r_k >= r_outdeg[r_a]) begin
                        if (w_req.wr_succ) begin
                            r_outdeg[r_a] <= r_outdeg[r_a] + 1'b1;
                            r_indeg[r_b]  <= r_indeg[r_b] + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DUP_CHK;
                    end
                end
                S_DUP_CHK: begin
                    r_k <= r_k + 1'b1;
                    r_state <= (w_rdata == r_b) ? S_IDLE : S_DUP_REQ;
                end
                S_SCAN: begin
                    // Forward pass: next unvisited vertex; reversed: latest finish.
                    if (r_scan >= r_n) begin
                        if (!r_rev) begin
                            if (!r_cycle) begin
                                r_state <= (r_ocnt == '0) ? S_CLEAR : S_EMIT;
                            end else begin
                                r_rev <= 1'b1;
                                r_visited <= '0;
                                r_scan <= '0;
                                r_bestok <= 1'b0;
                                r_bestf <= '0;
                            end
                        end else if (r_bestok) begin
                            r_wv[0] <= r_best;
                            r_state <= S_DFS_START;
                        end else begin
                            r_state <= S_CLEAR;
                        end
                    end else begin
                        r_scan <= r_scan + 1'b1;
                        if (!r_rev) begin
                            if (!r_visited[r_scan[VW-1:0]]) begin
                                r_wv[0] <= r_scan[VW-1:0];
                                r_state <= S_DFS_START;
                            end
                        end else if (!r_visited[r_scan[VW-1:0]] &&
                                     r_finish[r_scan[VW-1:0]] > r_bestf) begin
                            r_bestf  <= r_finish[r_scan[VW-1:0]];
                            r_best   <= r_scan[VW-1:0];
                            r_bestok <= 1'b1;
                        end
                    end
                end
                S_DFS_START: begin
                    r_visited[r_wv[0]] <= 1'b1;
                    r_onpath[r_wv[0]]  <= 1'b1;
                    r_we[0] <= '0;
                    r_depth <= CW'(1);
                    if (r_rev) begin
                        r_ocnt <= '0;
                    end
                    r_state <= S_DFS_TOP;
                end
                S_DFS_TOP: begin
                    if (r_depth == '0) begin
                        if (r_rev) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else if (r_we[w_top[VW-1:0]] < w_deg) begin
                        r_state <= S_DFS_WAIT;
                    end else begin
                        r_onpath[w_v] <= 1'b0;
                        r_depth <= w_top;
                        if (!r_rev) begin
                            r_finish[w_v] <= r_fcnt + 1'b1;
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_ord[r_ocnt[VW-1:0]] <= w_v;
                        r_ocnt <= r_ocnt + 1'b1;
                    end
                end
                S_DFS_WAIT: begin
                    r_state <= S_DFS_EDGE;
                end
                S_DFS_EDGE: begin
                    r_we[w_top[VW-1:0]] <= r_we[w_top[VW-1:0]] + 1'b1;
                    if (CW'(w_rdata) < r_n) begin
                        if (!r_visited[w_rdata]) begin
                            r_visited[w_rdata] <= 1'b1;
                            r_onpath[w_rdata]  <= 1'b1;
                            r_wv[r_depth[VW-1:0]] <= w_rdata;
                            r_we[r_depth[VW-1:0]] <= '0;
                            r_depth <= r_depth + 1'b1;
                        end else if (r_onpath[w_rdata] && !r_rev) begin
                            r_cycle <= 1'b1;
                        end
                    end
                    r_state <= S_DFS_TOP;
                end
                S_EMIT: begin
                    if (!r_ovalid || o_out.ready) begin
                        if (r_ocnt == '0) begin
                            r_comp <= r_comp + 1'b1;
                            r_scan <= '0;
                            r_bestok <= 1'b0;
                            r_bestf <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_odata.acyclic   <= !r_cycle;
                            r_odata.component <= r_cycle ? r_comp : 5'd0;
                            r_odata.vertex    <= 6'(r_ord[r_ocnt[VW-1:0] - 1'b1]) + 6'd1;
                            r_odata.last      <= w_final;
                            r_ocnt <= r_ocnt - 1'b1;
                            if (!r_cycle && r_ocnt == CW'(1)) begin
                                r_state <= S_CLEAR;
                            end
                        end
                    end
                end
                S_CLEAR: begin
                    for (int i = 0; i < NV; i++) begin
                        r_outdeg[i] <= '0;
                        r_indeg[i]  <= '0;
                    end
                    r_visited <= '0;
                    r_onpath  <= '0;
                    r_depth   <= '0;
                    r_ocnt    <= '0;
                    r_cycle   <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, i_in.ready, r_state == S_IDLE)
    `ASSERT_IMPL(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= CW'(NV))
    `ASSERT_NEXT(a_clear_deg, i_clk, i_rst_n, r_state == S_CLEAR, r_outdeg[0] == '0)
endmodule

[rtl/core/dgts_adj_mem.sv]
// Successor and predecessor list memories with registered reads.
module dgts_adj_mem (
    input  logic                          i_clk,
    input  dgts_pkg::t_adj_req            i_req,
    output logic [dgts_pkg::VW-1:0]       o_rdata
);
    localparam int Depth = dgts_pkg::MaxVertices * dgts_pkg::MaxDegree;
    logic [dgts_pkg::VW-1:0] r_succ [Depth];
    logic [dgts_pkg::VW-1:0] r_pred [Depth];
    logic [dgts_pkg::VW-1:0] r_rs;
    logic [dgts_pkg::VW-1:0] r_rp;
    logic                    r_sel;

    // Successor list memory.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_succ) begin
            r_succ[i_req.succ_waddr] <= i_req.succ_wdata;
        end
        r_rs <= r_succ[i_req.raddr];
    end

    // Predecessor list memory.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_pred) begin
            r_pred[i_req.pred_waddr] <= i_req.pred_wdata;
        end
        r_rp  <= r_pred[i_req.raddr];
        r_sel <= i_req.rd_pred;
    end

    assign o_rdata = r_sel ? r_rp : r_rs;
endmodule
